// ----- hdl/hbeg_pkg.sv -----
// Package for the harmonic bond energy and gradient block.
// Holds the payload and position types, mode and register codes, and the state enums.
// It depends on nothing; every module in hdl/ imports it.
package hbeg_pkg;

	localparam int HBEG_MAX_ATOMS = 1024;
	localparam int IDX_W          = 10;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 32;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_BOND  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAD_ENABLE = 1'b1;

	localparam logic [31:0] AMPLITUDE_RESET = 32'h0001_0000;
	localparam logic [47:0] ENERGY_MAX      = 48'hFFFF_FFFF_FFFF;
	localparam logic signed [54:0] GRAD_HI  = 55'sd140737488355327;
	localparam logic signed [54:0] GRAD_LO  = -55'sd140737488355328;

	typedef struct packed {
		logic [1:0]         mode;
		logic [IDX_W-1:0]   atom_index;
		logic [IDX_W-1:0]   second_atom;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [31:0]        rest_length;
		logic               last;
	} hbeg_in_t;

	typedef struct packed {
		logic [47:0]        energy;
		logic signed [47:0] grad_out_x;
		logic signed [47:0] grad_out_y;
		logic signed [47:0] grad_out_z;
		logic               done_res;
		logic               saturated;
	} hbeg_out_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pos_t;

	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
	} grad_t;

	typedef struct packed {
		logic        start;
		pos_t        pos_i;
		pos_t        pos_j;
		logic [31:0] rest;
		logic [31:0] amp;
		logic        grad_en;
	} bond_req_t;

	typedef struct packed {
		logic               done;
		logic               grad_valid;
		logic [65:0]        term;
		logic signed [53:0] g_x;
		logic signed [53:0] g_y;
		logic signed [53:0] g_z;
	} bond_res_t;

	typedef enum logic [3:0] {
		T_CLEAR, T_IDLE, T_DECODE, T_RDG, T_RDI, T_RDJ, T_RUN, T_WAIT,
		T_GI_RD, T_GI_WR, T_GJ_RD, T_GJ_WR, T_FINISH
	} top_state_t;

	typedef enum logic [4:0] {
		B_IDLE, B_SQ, B_SQ_ACC, B_SQRT, B_T, B_TT, B_T2, B_EA, B_EB, B_EC,
		B_P, B_PW, B_DIV_INIT, B_DIV, B_G1, B_G2, B_G3, B_DONE
	} bond_state_t;

endpackage

// ----- hdl/harmonic_bond_energy_gradient_top.sv -----
// Top level of the harmonic bond energy and gradient block.
// Holds the position and gradient memories, the energy total and the item sequencer.
// Depends on hbeg_pkg and hbeg_bond_unit.
//
//   Channel   Dir  Handshake            Payload
//   in        in   in_valid/in_ready    in_data  (hbeg_in_t)
//   out       out  out_valid/out_ready  out_data (hbeg_out_t)
//   cfg       in   cfg_we               cfg_index, cfg_data
//
// A bond with gradients is dominated by three 32-step divisions and a 33-step square root
// in the bond unit.
// A clear sweeps the gradient memory one entry a cycle.
// After reset the same sweep runs before in_ready first rises.
// One item is in work at a time; a finished result waits in the output register,
// and the next item is taken while it waits.
module harmonic_bond_energy_gradient_top
	import hbeg_pkg::*;
#(
	parameter int MAX_ATOMS = HBEG_MAX_ATOMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hbeg_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hbeg_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

	top_state_t state_q, state_d;

	logic          boot_q;
	logic [AW-1:0] clr_cnt_q;
	logic [47:0]   energy_q;
	logic          clip_q;
	logic [31:0]   amp_q;
	logic          gen_q;
	logic          out_valid_q;
	hbeg_out_t     out_q;
	hbeg_in_t      req_q;
	pos_t          pi_q;
	grad_t         gout_q;

	pos_t  pos_mem [MAX_ATOMS];
	grad_t grad_mem [MAX_ATOMS];
	pos_t  pos_rdata_q;
	grad_t grad_rdata_q;

	logic          pos_we;
	logic [AW-1:0] pos_addr;
	logic          grad_we;
	logic [AW-1:0] grad_addr;
	grad_t         grad_wdata;
	logic          a_ok, b_ok;
	logic [AW-1:0] a_addr, b_addr;
	logic          clr_last;
	logic          take_out;
	logic [47:0]   headroom;
	logic          e_clip;
	logic [2:0]    g_clip;
	bond_req_t     breq;
	bond_res_t     bres;

	typedef struct packed {
		logic signed [47:0] value;
		logic               clip;
	} sat_t;

	function automatic sat_t sat_add(logic signed [47:0] acc, logic signed [53:0] g);
		logic signed [54:0] sum;
		sat_t r;
		sum = 55'(acc) + 55'(g);
		if (sum > GRAD_HI) begin
			r.value = GRAD_HI[47:0];
			r.clip  = 1'b1;
		end else if (sum < GRAD_LO) begin
			r.value = GRAD_LO[47:0];
			r.clip  = 1'b1;
		end else begin
			r.value = sum[47:0];
			r.clip  = 1'b0;
		end
		return r;
	endfunction

	hbeg_bond_unit u_bond (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (breq),
		.res    (bres)
	);

	always_comb begin
		a_ok     = {22'b0, req_q.atom_index} < 32'(MAX_ATOMS);
		b_ok     = {22'b0, req_q.second_atom} < 32'(MAX_ATOMS);
		a_addr   = AW'(req_q.atom_index);
		b_addr   = AW'(req_q.second_atom);
		clr_last = (clr_cnt_q == AW'(MAX_ATOMS - 1));
		take_out = !out_valid_q || out_ready;
		headroom = ENERGY_MAX - energy_q;
		e_clip   = bres.term > {18'b0, headroom};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_CLEAR:  if (clr_last) state_d = boot_q ? T_IDLE : T_FINISH;
			T_IDLE:   if (in_valid) state_d = T_DECODE;
			T_DECODE: begin
				case (req_q.mode)
					MODE_LOAD:  state_d = T_FINISH;
					MODE_BOND:  state_d = (a_ok && b_ok) ? T_RDI : T_FINISH;
					MODE_READ:  state_d = T_RDG;
					MODE_CLEAR: state_d = T_CLEAR;
					default:    state_d = T_FINISH;
				endcase
			end
			T_RDG:    state_d = T_FINISH;
			T_RDI:    state_d = T_RDJ;
			T_RDJ:    state_d = T_RUN;
			T_RUN:    state_d = T_WAIT;
			T_WAIT:   if (bres.done) state_d = bres.grad_valid ? T_GI_RD : T_FINISH;
			T_GI_RD:  state_d = T_GI_WR;
			T_GI_WR:  state_d = T_GJ_RD;
			T_GJ_RD:  state_d = T_GJ_WR;
			T_GJ_WR:  state_d = T_FINISH;
			T_FINISH: if (take_out) state_d = T_IDLE;
			default:  state_d = T_IDLE;
		endcase
	end

	always_comb begin
		sat_t sx, sy, sz;
		in_ready   = (state_q == T_IDLE);
		pos_we     = (state_q == T_DECODE) && (req_q.mode == MODE_LOAD) && a_ok;
		pos_addr   = (state_q == T_RDJ) ? b_addr : a_addr;
		grad_we    = 1'b0;
		grad_addr  = a_addr;
		grad_wdata = '0;
		g_clip     = '0;
		sx         = sat_add(grad_rdata_q.x, bres.g_x);
		sy         = sat_add(grad_rdata_q.y, bres.g_y);
		sz         = sat_add(grad_rdata_q.z, bres.g_z);
		case (state_q)
			T_CLEAR: begin
				grad_we   = 1'b1;
				grad_addr = clr_cnt_q;
			end
			T_GI_WR: begin
				grad_we = 1'b1;
			end
			T_GJ_RD: begin
				grad_addr = b_addr;
			end
			T_GJ_WR: begin
				grad_we   = 1'b1;
				grad_addr = b_addr;
				sx        = sat_add(grad_rdata_q.x, -bres.g_x);
				sy        = sat_add(grad_rdata_q.y, -bres.g_y);
				sz        = sat_add(grad_rdata_q.z, -bres.g_z);
			end
			default: begin
			end
		endcase
		if (state_q == T_GI_WR || state_q == T_GJ_WR) begin
			grad_wdata = '{x: sx.value, y: sy.value, z: sz.value};
			g_clip     = {sz.clip, sy.clip, sx.clip};
		end
		breq.start   = (state_q == T_RUN);
		breq.pos_i   = pi_q;
		breq.pos_j   = pos_rdata_q;
		breq.rest    = req_q.rest_length;
		breq.amp     = amp_q;
		breq.grad_en = gen_q;
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_addr] <= '{x: req_q.coord_x, y: req_q.coord_y, z: req_q.coord_z};
		end
		pos_rdata_q <= pos_mem[pos_addr];
	end

	always_ff @(posedge clk) begin
		if (grad_we) begin
			grad_mem[grad_addr] <= grad_wdata;
		end
		grad_rdata_q <= grad_mem[grad_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_CLEAR;
			boot_q      <= 1'b1;
			clr_cnt_q   <= '0;
			energy_q    <= '0;
			clip_q      <= 1'b0;
			amp_q       <= AMPLITUDE_RESET;
			gen_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_AMPLITUDE:   amp_q <= cfg_data;
					REG_GRAD_ENABLE: gen_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (state_q == T_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_last) begin
					boot_q <= 1'b0;
				end
			end
			if (state_q == T_DECODE && req_q.mode == MODE_CLEAR) begin
				energy_q  <= '0;
				clip_q    <= 1'b0;
				clr_cnt_q <= '0;
			end
			if (state_q == T_WAIT && bres.done) begin
				if (e_clip) begin
					energy_q <= ENERGY_MAX;
					clip_q   <= 1'b1;
				end else begin
					energy_q <= energy_q + bres.term[47:0];
				end
			end
			if (g_clip != '0) begin
				clip_q <= 1'b1;
			end
			if (state_q == T_FINISH && take_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= in_data;
			gout_q <= '0;
		end
		if (state_q == T_RDG && a_ok) begin
			gout_q <= grad_rdata_q;
		end
		if (state_q == T_RDJ) begin
			pi_q <= pos_rdata_q;
		end
		if (state_q == T_FINISH && take_out) begin
			out_q.energy     <= energy_q;
			out_q.grad_out_x <= gout_q.x;
			out_q.grad_out_y <= gout_q.y;
			out_q.grad_out_z <= gout_q.z;
			out_q.done_res   <= (req_q.mode == MODE_BOND) && req_q.last;
			out_q.saturated  <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		bres.done |-> (state_q == T_WAIT))
		else $error("Bond unit finished while the sequencer was not waiting for it.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == T_FINISH))
		else $error("Result became valid outside the finish step.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(energy_q) |-> $past(state_q == T_WAIT || state_q == T_DECODE))
		else $error("Energy total changed outside a bond or a clear.");

endmodule

// ----- hdl/hbeg_bond_unit.sv -----
// Bond arithmetic for the harmonic bond block: distance, energy term and gradient terms.
// One shared multiplier and one shared compare-subtract unit run under a small sequencer.
// Depends on hbeg_pkg.
module hbeg_bond_unit
	import hbeg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bond_req_t req,
	output bond_res_t res
);

	bond_state_t state_q, state_d;

	logic [5:0]         cnt_q;
	logic [1:0]         k_q;
	logic [32:0]        mag_q [3];
	logic [2:0]         neg_q;
	logic [65:0]        sum_q;
	logic [36:0]        rem_q;
	logic [33:0]        root_q;
	logic [33:0]        t_q;
	logic               tneg_q;
	logic [49:0]        t2_q;
	logic [63:0]        acc_q;
	logic [65:0]        term_q;
	logic [49:0]        p_q;
	logic [31:0]        quo_q;
	logic               nbit_q;
	logic signed [53:0] g_q [3];
	logic               gvalid_q;
	logic [31:0]        amp_q;
	logic [31:0]        rest_q;
	logic               gen_q;
	logic [67:0]        prod_q;

	logic signed [31:0] pi [3];
	logic signed [31:0] pj [3];
	logic signed [32:0] dl [3];
	logic [32:0]        mag [3];
	logic [33:0]        op_a, op_b;
	logic [36:0]        sub_a, sub_b;
	logic [37:0]        diff;
	logic               ge;
	logic [81:0]        full;
	logic [51:0]        gmag;
	logic               tneg;

	always_comb begin
		pi[0] = req.pos_i.x;
		pi[1] = req.pos_i.y;
		pi[2] = req.pos_i.z;
		pj[0] = req.pos_j.x;
		pj[1] = req.pos_j.y;
		pj[2] = req.pos_j.z;
		for (int k = 0; k < 3; k++) begin
			dl[k]  = 33'(pi[k]) - 33'(pj[k]);
			mag[k] = dl[k][32] ? 33'(-dl[k]) : 33'(dl[k]);
		end
	end

	always_comb begin
		op_a  = '0;
		op_b  = '0;
		sub_a = '0;
		sub_b = '0;
		case (state_q)
			B_SQ: begin
				op_a = {1'b0, mag_q[k_q]};
				op_b = {1'b0, mag_q[k_q]};
			end
			B_TT: begin
				op_a = t_q;
				op_b = t_q;
			end
			B_EA: begin
				op_a = {2'b00, amp_q};
				op_b = {2'b00, t2_q[31:0]};
			end
			B_EB: begin
				op_a = {2'b00, amp_q};
				op_b = {16'b0, t2_q[49:32]};
			end
			B_P: begin
				op_a = {2'b00, amp_q};
				op_b = t_q;
			end
			B_G1: begin
				op_a = {2'b00, p_q[31:0]};
				op_b = {2'b00, quo_q};
			end
			B_G2: begin
				op_a = {16'b0, p_q[49:32]};
				op_b = {2'b00, quo_q};
			end
			B_SQRT: begin
				sub_a = {rem_q[34:0], sum_q[65:64]};
				sub_b = {1'b0, root_q, 2'b01};
			end
			B_DIV: begin
				sub_a = {2'b00, rem_q[33:0], nbit_q};
				sub_b = {3'b000, root_q};
			end
			default: begin
			end
		endcase
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = !diff[37];
		full = {18'b0, acc_q} + {prod_q[49:0], 32'b0};
		gmag = full[81:30];
		tneg = root_q < {2'b00, rest_q};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:     if (req.start) state_d = B_SQ;
			B_SQ:       state_d = B_SQ_ACC;
			B_SQ_ACC:   state_d = (k_q == 2'd2) ? B_SQRT : B_SQ;
			B_SQRT:     if (cnt_q == '0) state_d = B_T;
			B_T:        state_d = B_TT;
			B_TT:       state_d = B_T2;
			B_T2:       state_d = B_EA;
			B_EA:       state_d = B_EB;
			B_EB:       state_d = B_EC;
			B_EC:       state_d = (gen_q && root_q != '0) ? B_P : B_DONE;
			B_P:        state_d = B_PW;
			B_PW:       state_d = B_DIV_INIT;
			B_DIV_INIT: state_d = B_DIV;
			B_DIV:      if (cnt_q == '0) state_d = B_G1;
			B_G1:       state_d = B_G2;
			B_G2:       state_d = B_G3;
			B_G3:       state_d = (k_q == 2'd2) ? B_DONE : B_DIV_INIT;
			B_DONE:     state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	always_comb begin
		res.done       = (state_q == B_DONE);
		res.grad_valid = gvalid_q;
		res.term       = term_q;
		res.g_x        = g_q[0];
		res.g_y        = g_q[1];
		res.g_z        = g_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		case (state_q)
			B_IDLE: begin
				if (req.start) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag[k];
						neg_q[k] <= dl[k][32];
					end
					amp_q  <= req.amp;
					rest_q <= req.rest;
					gen_q  <= req.grad_en;
					sum_q  <= '0;
					k_q    <= '0;
				end
			end
			B_SQ_ACC: begin
				sum_q <= sum_q + prod_q[65:0];
				if (k_q == 2'd2) begin
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= 6'd32;
					k_q    <= '0;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			B_SQRT: begin
				rem_q  <= ge ? diff[36:0] : sub_a;
				root_q <= {root_q[32:0], ge};
				sum_q  <= {sum_q[63:0], 2'b00};
				cnt_q  <= cnt_q - 6'd1;
			end
			B_T: begin
				tneg_q <= tneg;
				t_q    <= tneg ? ({2'b00, rest_q} - root_q) : (root_q - {2'b00, rest_q});
			end
			B_T2: t2_q <= prod_q[65:16];
			B_EB: acc_q <= prod_q[63:0];
			B_EC: begin
				term_q   <= full[81:16];
				gvalid_q <= gen_q && (root_q != '0);
			end
			B_PW: p_q <= prod_q[65:16];
			B_DIV_INIT: begin
				rem_q  <= {5'b0, mag_q[k_q][32:1]};
				nbit_q <= mag_q[k_q][0];
				quo_q  <= '0;
				cnt_q  <= 6'd31;
			end
			B_DIV: begin
				rem_q  <= ge ? diff[36:0] : sub_a;
				quo_q  <= {quo_q[30:0], ge};
				nbit_q <= 1'b0;
				cnt_q  <= cnt_q - 6'd1;
			end
			B_G2: acc_q <= prod_q[63:0];
			B_G3: begin
				g_q[k_q] <= (tneg_q ^ neg_q[k_q]) ? -54'(gmag) : 54'(gmag);
				k_q      <= k_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- tb/tb_harmonic_bond_energy_gradient_top.sv -----
// Testbench for harmonic_bond_energy_gradient_top: directed and random items through the
// valid/ready channels, checked against a bit-exact energy and gradient predictor.
// Depends on hbeg_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_harmonic_bond_energy_gradient_top;
	import hbeg_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE       = HBEG_MAX_ATOMS + 80;
	localparam int PHASE_ITEMS  = 230;

	class bond_scoreboard;
		logic signed [31:0] px[HBEG_MAX_ATOMS];
		logic signed [31:0] py[HBEG_MAX_ATOMS];
		logic signed [31:0] pz[HBEG_MAX_ATOMS];
		logic signed [47:0] gx[HBEG_MAX_ATOMS];
		logic signed [47:0] gy[HBEG_MAX_ATOMS];
		logic signed [47:0] gz[HBEG_MAX_ATOMS];
		logic [47:0] energy;
		bit clip;
		logic [31:0] amp;
		bit grad_en;
		hbeg_out_t pending[$];
		int errors;

		function new();
			foreach (gx[k]) begin
				gx[k] = '0;
				gy[k] = '0;
				gz[k] = '0;
				px[k] = '0;
				py[k] = '0;
				pz[k] = '0;
			end
			energy = '0;
			clip = 0;
			amp = AMPLITUDE_RESET;
			grad_en = 1;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			if (idx == REG_AMPLITUDE) begin
				amp = v;
			end else begin
				grad_en = v[0];
			end
		endfunction

		function logic [63:0] sat_shift(logic [127:0] x, int sh);
			logic [127:0] s;
			s = x >> sh;
			return (s[127:64] != 0) ? '1 : s[63:0];
		endfunction

		function logic [33:0] floor_sqrt(logic [65:0] v);
			logic [67:0] root, rem, trial;
			root = '0;
			rem = '0;
			for (int k = 32; k >= 0; k--) begin
				rem = (rem << 2) | 68'(v[2*k +: 2]);
				trial = (root << 2) | 68'd1;
				if (rem >= trial) begin
					rem = rem - trial;
					root = (root << 1) | 68'd1;
				end else begin
					root = root << 1;
				end
			end
			return root[33:0];
		endfunction

		function logic signed [47:0] grad_acc(logic signed [47:0] acc, logic signed [63:0] g);
			logic signed [63:0] s;
			s = 64'(acc);
			s = s + g;
			if (s > 64'sd140737488355327) begin
				clip = 1;
				return GRAD_HI[47:0];
			end
			if (s < -64'sd140737488355328) begin
				clip = 1;
				return GRAD_LO[47:0];
			end
			return s[47:0];
		endfunction

		function void apply_bond(int i, int j, logic [31:0] rest);
			logic signed [32:0] dl[3];
			logic [32:0] mg[3];
			logic [65:0] ss;
			logic [33:0] d, t;
			logic tneg;
			logic [63:0] t2, term, p, u;
			logic signed [63:0] g;
			dl[0] = {px[i][31], px[i]} - {px[j][31], px[j]};
			dl[1] = {py[i][31], py[i]} - {py[j][31], py[j]};
			dl[2] = {pz[i][31], pz[i]} - {pz[j][31], pz[j]};
			ss = '0;
			for (int k = 0; k < 3; k++) begin
				mg[k] = dl[k][32] ? -dl[k] : dl[k];
				ss = ss + {33'b0, mg[k]} * {33'b0, mg[k]};
			end
			d = floor_sqrt(ss);
			tneg = d < {2'b0, rest};
			t = tneg ? {2'b0, rest} - d : d - {2'b0, rest};
			t2 = sat_shift({94'b0, t} * {94'b0, t}, 16);
			term = sat_shift({64'b0, t2} * {96'b0, amp}, 16);
			if (term > {16'b0, ENERGY_MAX} - {16'b0, energy}) begin
				energy = ENERGY_MAX;
				clip = 1;
			end else begin
				energy = energy + term[47:0];
			end
			if (!grad_en || d == 0) return;
			p = sat_shift({96'b0, amp} * {94'b0, t}, 16);
			for (int k = 0; k < 3; k++) begin
				u = ({31'b0, mg[k]} << 31) / {30'b0, d};
				g = sat_shift({64'b0, p} * {64'b0, u}, 30);
				if (tneg != dl[k][32]) g = -g;
				if (k == 0) begin
					gx[i] = grad_acc(gx[i], g);
					gx[j] = grad_acc(gx[j], -g);
				end else if (k == 1) begin
					gy[i] = grad_acc(gy[i], g);
					gy[j] = grad_acc(gy[j], -g);
				end else begin
					gz[i] = grad_acc(gz[i], g);
					gz[j] = grad_acc(gz[j], -g);
				end
			end
		endfunction

		function void note_input(hbeg_in_t it);
			hbeg_out_t r;
			r = '0;
			case (it.mode)
				MODE_LOAD: begin
					px[it.atom_index] = it.coord_x;
					py[it.atom_index] = it.coord_y;
					pz[it.atom_index] = it.coord_z;
				end
				MODE_BOND: begin
					apply_bond(int'(it.atom_index), int'(it.second_atom), it.rest_length);
					r.done_res = it.last;
				end
				MODE_READ: begin
					r.grad_out_x = gx[it.atom_index];
					r.grad_out_y = gy[it.atom_index];
					r.grad_out_z = gz[it.atom_index];
				end
				default: begin
					foreach (gx[k]) begin
						gx[k] = '0;
						gy[k] = '0;
						gz[k] = '0;
					end
					energy = '0;
					clip = 0;
				end
			endcase
			r.energy = energy;
			r.saturated = clip;
			pending.push_back(r);
		endfunction

		function void compare(string name, logic [47:0] e, logic [47:0] a);
			if (e !== a) begin
				$error("%s: expected %h, got %h", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(hbeg_out_t a);
			hbeg_out_t e;
			if (pending.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			compare("energy", e.energy, a.energy);
			compare("grad_out_x", e.grad_out_x, a.grad_out_x);
			compare("grad_out_y", e.grad_out_y, a.grad_out_y);
			compare("grad_out_z", e.grad_out_z, a.grad_out_z);
			compare("done_res", 48'(e.done_res), 48'(a.done_res));
			compare("saturated", 48'(e.saturated), 48'(a.saturated));
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	hbeg_in_t in_data;
	logic out_valid;
	logic out_ready;
	hbeg_out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bond_scoreboard sb = new();
	int cycles = 0;
	logic quiet = 0;
	logic hold_req = 0;
	logic hold_taken = 0;
	int hold_left = 0;
	int loaded[$];

	harmonic_bond_energy_gradient_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_data);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1;
			hold_left <= 600;
			out_ready <= 0;
		end else begin
			out_ready <= quiet || ($urandom_range(0, 99) >= 13);
		end
	end

	task automatic send(hbeg_in_t it);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		if (it.mode == MODE_LOAD) loaded.push_back(int'(it.atom_index));
		if (!quiet && $urandom_range(0, 99) < 13) begin
			in_valid <= 0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic hbeg_in_t make_item(logic [1:0] mode, int a, int b, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] rest, logic last);
		hbeg_in_t it;
		it.mode = mode;
		it.atom_index = IDX_W'(a);
		it.second_atom = IDX_W'(b);
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		it.rest_length = rest;
		it.last = last;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0, 1: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
			2: return $urandom_range(0, 1) ? ($urandom & 32'h0FFF_FFFF) : -($urandom & 32'h0FFF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	function automatic hbeg_in_t rand_item();
		hbeg_in_t it;
		int r;
		int a;
		r = $urandom_range(0, 99);
		it = make_item(MODE_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
			rand_coord(), rand_coord(), rand_coord(), $urandom, $urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1)) it.rest_length = $urandom_range(0, 32'h0040_0000);
		if (r < 15) begin
			it.mode = MODE_LOAD;
			a = $urandom_range(0, 9) < 7 ? $urandom_range(0, 63) : $urandom_range(0, 1023);
			it.atom_index = IDX_W'(a);
		end else if (r < 70) begin
			it.mode = MODE_BOND;
			it.atom_index = IDX_W'(loaded[$urandom_range(0, loaded.size() - 1)]);
			it.second_atom = IDX_W'(loaded[$urandom_range(0, loaded.size() - 1)]);
		end else if (r < 98) begin
			it.mode = MODE_READ;
			if ($urandom_range(0, 3) != 0)
				it.atom_index = IDX_W'(loaded[$urandom_range(0, loaded.size() - 1)]);
		end else begin
			it.mode = MODE_CLEAR;
		end
		return it;
	endfunction

	initial begin
		logic [31:0] amps[5];
		logic ens[5];
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		send(make_item(MODE_LOAD, 0, 5, 0, 0, 0, 0, 0));
		send(make_item(MODE_LOAD, 1023, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1));
		send(make_item(MODE_LOAD, 1, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
		send(make_item(MODE_LOAD, 2, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 0, 0));
		send(make_item(MODE_LOAD, 3, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 0, 0));
		send(make_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_BOND, 0, 2, 0, 0, 0, 0, 0));
		send(make_item(MODE_BOND, 2, 0, 0, 0, 0, 32'hFFFF_FFFF, 1));
		send(make_item(MODE_BOND, 2, 3, 0, 0, 0, 32'h0001_0000, 0));
		send(make_item(MODE_BOND, 0, 0, 0, 0, 0, 32'h0000_8000, 1));
		send(make_item(MODE_READ, 2, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_BOND, 1, 1023, 0, 0, 0, 0, 1));
		send(make_item(MODE_READ, 1023, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_READ, 1, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_READ, 2, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_BOND, 0, 2, 0, 0, 0, 32'h0002_0000, 1));
		send(make_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
		drain();

		write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
		send(make_item(MODE_BOND, 1, 1023, 0, 0, 0, 0, 0));
		send(make_item(MODE_READ, 1, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send(make_item(MODE_BOND, 1, 1023, 0, 0, 0, 32'hFFFF_FFFF, 1));
		send(make_item(MODE_READ, 1023, 0, 0, 0, 0, 0, 0));
		drain();

		amps = '{AMPLITUDE_RESET, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom_range(0, 32'h0004_0000)};
		ens = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_AMPLITUDE, amps[ph]);
			write_reg(REG_GRAD_ENABLE, CFG_DATA_W'(ens[ph]));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 40) hold_req <= 1;
				if (ph == 3 && n == 60) quiet <= 1;
				if (ph == 3 && n == 160) quiet <= 0;
				send(rand_item());
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/hbeg_pkg.sv
hdl/hbeg_bond_unit.sv
hdl/harmonic_bond_energy_gradient_top.sv
tb/tb_harmonic_bond_energy_gradient_top.sv
